// ===== rtl/core/job_dispatch_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the job dispatch table
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef JOB_DISPATCH_TABLE_ASSERT_SVH
`define JOB_DISPATCH_TABLE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define JDT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define JDT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/core/jdt_pkg.sv =====
// ----------------------------------------------------------------------------
// jdt_pkg
// Shared constants, codes and word types of the job dispatch table.
// ----------------------------------------------------------------------------
package jdt_pkg;

   localparam int MAX_JOBS   = 64;
   localparam int IDX_W      = $clog2(MAX_JOBS);
   localparam int COUNT_W    = $clog2(MAX_JOBS + 1);

   // find-first search is split into groups of eight flags
   localparam int PICK_GRP   = 8;
   localparam int PICK_OFF_W = $clog2(PICK_GRP);
   localparam int PICK_NGRP  = MAX_JOBS / PICK_GRP;
   localparam int PICK_GRP_W = $clog2(PICK_NGRP);

   localparam logic [2:0] ACT_CREATE   = 3'd0;
   localparam logic [2:0] ACT_ACQUIRE  = 3'd1;
   localparam logic [2:0] ACT_COMPLETE = 3'd2;
   localparam logic [2:0] ACT_RELEASE  = 3'd3;
   localparam logic [2:0] ACT_READ     = 3'd4;

   localparam logic [1:0] STATUS_WAITING   = 2'd0;
   localparam logic [1:0] STATUS_ASSIGNED  = 2'd1;
   localparam logic [1:0] STATUS_COMPLETED = 2'd2;

   localparam logic [15:0] NO_WORKER = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  kind;
      logic [15:0] target_flag;
      logic [7:0]  building;
      logic [15:0] work_time;
      logic [15:0] worker_id;
      logic [5:0]  entry_id;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  result_id;
      logic [1:0]  entry_status;
      logic [7:0]  entry_kind;
      logic [15:0] entry_target;
      logic [7:0]  entry_building;
      logic [15:0] entry_worker;
      logic [15:0] entry_time;
      logic [6:0]  waiting_count;
      logic [6:0]  assigned_count;
      logic [6:0]  completed_count;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  kind;
      logic [15:0] target;
      logic [7:0]  building;
      logic [15:0] worker;
      logic [15:0] work_time;
   } entry_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } pick_type;

endpackage

// ===== rtl/core/jdt_req_if.sv =====
// ----------------------------------------------------------------------------
// jdt_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface jdt_req_if;
   import jdt_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/core/jdt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// jdt_rsp_if
// Response channel: valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface jdt_rsp_if;
   import jdt_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/core/jdt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// jdt_entry_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jdt_entry_mem (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [jdt_pkg::IDX_W-1:0]     rd_addr,
   output jdt_pkg::entry_type            rd_data,
   input  logic                          wr_en,
   input  logic [jdt_pkg::IDX_W-1:0]     wr_addr,
   input  jdt_pkg::entry_type            wr_data
);
   import jdt_pkg::*;

   entry_type mem [MAX_JOBS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/jdt_pick.sv =====
// ----------------------------------------------------------------------------
// jdt_pick
// Find-first over the waiting flags: lowest set flag, searched in groups.
// ----------------------------------------------------------------------------
module jdt_pick (
   input  logic [jdt_pkg::MAX_JOBS-1:0] waiting_vec,
   output jdt_pkg::pick_type            pick
);
   import jdt_pkg::*;

   logic [PICK_NGRP-1:0]  grp_any;
   logic [PICK_OFF_W-1:0] grp_off [PICK_NGRP];
   logic [PICK_GRP_W-1:0] grp_sel;

   // lowest set flag inside each group
   always_comb begin
      for (int g = 0; g < PICK_NGRP; g++) begin
         grp_any[g] = |waiting_vec[g*PICK_GRP +: PICK_GRP];
         grp_off[g] = '0;
         for (int k = PICK_GRP - 1; k >= 0; k--) begin
            if (waiting_vec[g*PICK_GRP + k]) begin
               grp_off[g] = PICK_OFF_W'(k);
            end
         end
      end
   end

   // lowest group holding a set flag
   always_comb begin
      grp_sel = '0;
      for (int g = PICK_NGRP - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = PICK_GRP_W'(g);
         end
      end
   end

   assign pick.found = |grp_any;
   assign pick.idx   = {grp_sel, grp_off[grp_sel]};
endmodule

// ===== rtl/core/job_dispatch_table.sv =====
// ----------------------------------------------------------------------------
// job_dispatch_table
// Append-only job table with create, acquire, complete, release and read.
// ----------------------------------------------------------------------------
// Each request has an accept step and a write-back step. In the accept cycle
// the target entry is chosen (fill position for create, lowest waiting entry
// for acquire, the given id otherwise) and its read is issued to the entry
// memory; in the write-back step the read data is modified, written back and
// the response word is loaded into the output register. The single-ported
// read of the entry memory sets this pace: a new request is taken only after
// the write-back. A finished response waiting in the output register does
// not block the next request; only the write-back cycle waits for the output
// register to free up. Entries are stored without reset and need no clearing
// pass: only read data of entries below the fill count is ever used, and
// each of those was written by create. Every response carries the waiting,
// assigned and completed counts after the step; a worker value of all ones
// means no worker.
// ----------------------------------------------------------------------------
module job_dispatch_table (
   input  logic      clock,
   input  logic      reset,
   jdt_req_if.sink   req_bus,
   jdt_rsp_if.source rsp_bus
);
   import jdt_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   req_word_type         op_ff;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic                 create_ok_ff, found_ff, id_ok_ff;
   logic [COUNT_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0]   waiting_ff, waiting_in;
   logic [COUNT_W-1:0]   assigned_ff, assigned_in;
   logic [COUNT_W-1:0]   completed_ff, completed_in;
   logic [MAX_JOBS-1:0]  waiting_vec_ff, waiting_vec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                 req_fire;
   logic                 exec_fire;
   pick_type             pick;
   entry_type            rd_entry;
   logic                 wr_req;
   entry_type            wr_entry;
   logic [1:0]           new_status;

   // ---------------------------------------------------------------------
   // Handshake: take a word whenever no request is in its write-back cycle.
   // Retire the write-back only when the output register is free.
   // ---------------------------------------------------------------------
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign exec_fire     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.word  = rsp_word_ff;

   // lowest-numbered waiting entry, from the flag vector
   jdt_pick u_pick (
      .waiting_vec (waiting_vec_ff),
      .pick        (pick)
   );

   // choose the entry this request touches
   always_comb begin
      case (req_bus.word.action)
         ACT_CREATE:  addr_in = fill_ff[IDX_W-1:0];
         ACT_ACQUIRE: addr_in = pick.idx;
         default:     addr_in = IDX_W'(req_bus.word.entry_id);
      endcase
   end

   jdt_entry_mem u_entry_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (addr_in),
      .rd_data (rd_entry),
      .wr_en   (exec_fire && wr_req),
      .wr_addr (addr_ff),
      .wr_data (wr_entry)
   );

   // ---------------------------------------------------------------------
   // Hold the request and its checks for the write-back cycle.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff        <= req_bus.word;
         addr_ff      <= addr_in;
         create_ok_ff <= (fill_ff < COUNT_W'(MAX_JOBS));
         found_ff     <= pick.found;
         id_ok_ff     <= (COUNT_W'(req_bus.word.entry_id) < fill_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Modify: build the write-back entry, the new counts and the response.
   // ---------------------------------------------------------------------
   always_comb begin
      wr_req         = 1'b0;
      wr_entry       = rd_entry;
      fill_in        = fill_ff;
      waiting_in     = waiting_ff;
      assigned_in    = assigned_ff;
      completed_in   = completed_ff;
      waiting_vec_in = waiting_vec_ff;
      new_status     = (op_ff.action == ACT_COMPLETE) ? STATUS_COMPLETED : STATUS_WAITING;
      rsp_word_in    = '0;

      case (op_ff.action)
         ACT_CREATE: begin
            if (create_ok_ff) begin
               wr_req             = 1'b1;
               wr_entry.status    = STATUS_WAITING;
               wr_entry.kind      = op_ff.kind;
               wr_entry.target    = op_ff.target_flag;
               wr_entry.building  = op_ff.building;
               wr_entry.worker    = NO_WORKER;
               wr_entry.work_time = op_ff.work_time;
               fill_in            = fill_ff + COUNT_W'(1);
               waiting_in         = waiting_ff + COUNT_W'(1);
               waiting_vec_in[addr_ff] = 1'b1;
               rsp_word_in.ok        = 1'b1;
               rsp_word_in.result_id = 6'(addr_ff);
            end
         end
         ACT_ACQUIRE: begin
            if (found_ff) begin
               wr_req          = 1'b1;
               wr_entry.status = STATUS_ASSIGNED;
               wr_entry.worker = op_ff.worker_id;
               waiting_in      = waiting_ff - COUNT_W'(1);
               assigned_in     = assigned_ff + COUNT_W'(1);
               waiting_vec_in[addr_ff] = 1'b0;
               rsp_word_in.ok        = 1'b1;
               rsp_word_in.result_id = 6'(addr_ff);
            end
         end
         ACT_COMPLETE, ACT_RELEASE: begin
            if (id_ok_ff) begin
               wr_req          = 1'b1;
               wr_entry.status = new_status;
               wr_entry.worker = NO_WORKER;
               // drop the entry from its old class
               case (rd_entry.status)
                  STATUS_WAITING:   waiting_in   = waiting_ff - COUNT_W'(1);
                  STATUS_ASSIGNED:  assigned_in  = assigned_ff - COUNT_W'(1);
                  STATUS_COMPLETED: completed_in = completed_ff - COUNT_W'(1);
                  default:          ;
               endcase
               // and add it to the new one
               if (new_status == STATUS_WAITING) begin
                  waiting_in = waiting_in + COUNT_W'(1);
               end else begin
                  completed_in = completed_in + COUNT_W'(1);
               end
               waiting_vec_in[addr_ff] = (new_status == STATUS_WAITING);
               rsp_word_in.ok = 1'b1;
            end
         end
         ACT_READ: begin
            if (id_ok_ff) begin
               rsp_word_in.ok             = 1'b1;
               rsp_word_in.entry_status   = rd_entry.status;
               rsp_word_in.entry_kind     = rd_entry.kind;
               rsp_word_in.entry_target   = rd_entry.target;
               rsp_word_in.entry_building = rd_entry.building;
               rsp_word_in.entry_worker   = rd_entry.worker;
               rsp_word_in.entry_time     = rd_entry.work_time;
            end
         end
         default: ;
      endcase

      rsp_word_in.waiting_count   = 7'(waiting_in);
      rsp_word_in.assigned_count  = 7'(assigned_in);
      rsp_word_in.completed_count = 7'(completed_in);
   end

   // ---------------------------------------------------------------------
   // Sequencer and output register.
   // ---------------------------------------------------------------------
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_fire ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = exec_fire ? ST_IDLE : ST_EXEC;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         fill_ff        <= '0;
         waiting_ff     <= '0;
         assigned_ff    <= '0;
         completed_ff   <= '0;
         waiting_vec_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance table state only as the response is loaded
         if (exec_fire) begin
            fill_ff        <= fill_in;
            waiting_ff     <= waiting_in;
            assigned_ff    <= assigned_in;
            completed_ff   <= completed_in;
            waiting_vec_ff <= waiting_vec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end
endmodule

// ===== rtl/core/jdt_checker.sv =====
// ----------------------------------------------------------------------------
// jdt_checker
// Port-level checks of the job dispatch table, bound to the top level.
// ----------------------------------------------------------------------------
`include "job_dispatch_table_assert.svh"

module jdt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input jdt_pkg::rsp_word_type rsp_word
);
   import jdt_pkg::*;

   logic [COUNT_W+1:0] count_sum;

   assign count_sum = (COUNT_W+2)'(rsp_word.waiting_count)
                    + (COUNT_W+2)'(rsp_word.assigned_count)
                    + (COUNT_W+2)'(rsp_word.completed_count);

   // hold a stalled response word
   `JDT_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `JDT_ASSERT_NEXT(a_rsp_word_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word))
   // one request in flight: no word taken in the write-back cycle
   `JDT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   // the three class counts never sum to more than the table
   `JDT_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, count_sum <= (COUNT_W+2)'(MAX_JOBS))
endmodule

bind job_dispatch_table jdt_checker u_jdt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_word  (rsp_bus.word)
);
